>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the merge unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition holds at every clock edge outside reset.
`define KWM_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("%m: assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define KWM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define KWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define KWM_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define KWM_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define KWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/kwm_pkg.sv
// Shared constants, codes and control/status types of the merge unit.
package kwm_pkg;

    localparam int VALUE_W        = 32;
    localparam int ACTION_W       = 2;
    localparam int LIST_IDX_W     = 3;
    localparam int STATUS_W       = 2;

    localparam int NUM_LISTS_DEF  = 8;
    localparam int LIST_DEPTH_DEF = 64;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TAKE   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TAKEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic scan_step;
        logic drain;
        logic load_out;
    } kwm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_take;
        logic scan_last;
        logic out_free;
    } kwm_stat_t;

endpackage

>>> rtl/kwm_ifs.sv
// Request and response channel interfaces of the merge unit.
interface kwm_req_if;
    logic                              valid;
    logic                              ready;
    logic [kwm_pkg::ACTION_W-1:0]      action;
    logic [kwm_pkg::LIST_IDX_W-1:0]    list_index;
    logic signed [kwm_pkg::VALUE_W-1:0] value;

    modport source (output valid, action, list_index, value, input ready);
    modport sink   (input valid, action, list_index, value, output ready);
endinterface

interface kwm_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [kwm_pkg::STATUS_W-1:0]      status;
    logic signed [kwm_pkg::VALUE_W-1:0] taken_value;
    logic [kwm_pkg::LIST_IDX_W-1:0]    source_list;

    modport source (output valid, status, taken_value, source_list, input ready);
    modport sink   (input valid, status, taken_value, source_list, output ready);
endinterface

>>> rtl/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/kwm_ctrl.sv
// Sequencing state machine of the merge unit.
module kwm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  kwm_pkg::kwm_stat_t stat,
    output kwm_pkg::kwm_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_ready  = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.is_take ? S_SCAN : S_EMIT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.drain  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/kwm_dp.sv
// Datapath: list counters, element RAM, head scan and result register.
module kwm_dp #(
    parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  kwm_pkg::kwm_cmd_t                  cmd,
    output kwm_pkg::kwm_stat_t                 stat,
    input  logic [kwm_pkg::ACTION_W-1:0]       req_action,
    input  logic [kwm_pkg::LIST_IDX_W-1:0]     req_list_index,
    input  logic signed [kwm_pkg::VALUE_W-1:0] req_value,
    input  logic                               rsp_ready,
    output logic                               rsp_valid,
    output logic [kwm_pkg::STATUS_W-1:0]       rsp_status,
    output logic signed [kwm_pkg::VALUE_W-1:0] rsp_taken_value,
    output logic [kwm_pkg::LIST_IDX_W-1:0]     rsp_source_list
);

    localparam int VW = kwm_pkg::VALUE_W;
    localparam int IW = kwm_pkg::LIST_IDX_W;
    localparam int SW = kwm_pkg::STATUS_W;
    localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = LW + PW;

    // Held request
    logic [kwm_pkg::ACTION_W-1:0] act_reg;
    logic [IW-1:0]                idx_reg;
    logic [VW-1:0]                val_reg;

    // Per-list counters
    logic [CW-1:0] fill_reg [NUM_LISTS];
    logic [CW-1:0] fill_next [NUM_LISTS];
    logic [CW-1:0] rp_reg [NUM_LISTS];
    logic [CW-1:0] rp_next [NUM_LISTS];

    // Scan pipeline
    logic [LW-1:0] ptr_reg, ptr_next;
    logic          cand_vld_reg, cand_vld_next;
    logic [LW-1:0] cand_idx_reg, cand_idx_next;
    logic [CW-1:0] cand_rp_reg, cand_rp_next;
    logic          found_reg, found_next;
    logic [LW-1:0] best_idx_reg, best_idx_next;
    logic [CW-1:0] best_rp_reg, best_rp_next;
    logic [VW-1:0] best_val_reg, best_val_next;

    logic [SW-1:0] res_status_reg, res_status_next;

    // Output register
    logic          out_vld_reg, out_vld_next;
    logic [SW-1:0] out_status_reg, out_status_next;
    logic [VW-1:0] out_val_reg, out_val_next;
    logic [IW-1:0] out_src_reg, out_src_next;

    logic [LW-1:0] sel;
    logic [CW-1:0] fill_sel;
    logic [CW-1:0] rp_sel;
    logic          idx_ok;
    logic          room;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [VW-1:0] ram_rdata;

    assign sel      = cmd.scan_step ? ptr_reg : LW'(idx_reg);
    assign fill_sel = fill_reg[sel];
    assign rp_sel   = rp_reg[sel];
    assign idx_ok   = (32'(idx_reg) < NUM_LISTS);
    assign room     = (32'(fill_sel) < LIST_DEPTH);

    assign ram_we    = cmd.exec && (act_reg == kwm_pkg::ACT_APPEND) && idx_ok && room;
    assign ram_waddr = {sel, fill_sel[PW-1:0]};
    assign ram_raddr = {ptr_reg, rp_sel[PW-1:0]};

    kwm_ram #(
        .WIDTH (VW),
        .DEPTH (2 ** AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (val_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stat.is_take   = (act_reg == kwm_pkg::ACT_TAKE);
    assign stat.scan_last = (ptr_reg == LW'(NUM_LISTS - 1));
    assign stat.out_free  = !out_vld_reg || rsp_ready;

    always_comb
    begin
        fill_next       = fill_reg;
        rp_next         = rp_reg;
        ptr_next        = ptr_reg;
        cand_vld_next   = cand_vld_reg;
        cand_idx_next   = cand_idx_reg;
        cand_rp_next    = cand_rp_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_rp_next    = best_rp_reg;
        best_val_next   = best_val_reg;
        res_status_next = res_status_reg;
        out_vld_next    = out_vld_reg;
        out_status_next = out_status_reg;
        out_val_next    = out_val_reg;
        out_src_next    = out_src_reg;

        if (cmd.exec)
        begin
            ptr_next        = '0;
            cand_vld_next   = 1'b0;
            found_next      = 1'b0;
            res_status_next = kwm_pkg::ST_DONE;
            if (act_reg == kwm_pkg::ACT_CLEAR)
            begin
                for (int i = 0; i < NUM_LISTS; i++)
                begin
                    fill_next[i] = '0;
                    rp_next[i]   = '0;
                end
            end
            else if (act_reg == kwm_pkg::ACT_APPEND)
            begin
                if (ram_we)
                begin
                    fill_next[sel] = CW'(fill_sel + 1'b1);
                end
                else
                begin
                    res_status_next = kwm_pkg::ST_FULL;
                end
            end
        end

        // Issue stage: read head of list ptr if it still has elements
        if (cmd.scan_step)
        begin
            ptr_next      = LW'(ptr_reg + 1'b1);
            cand_vld_next = (rp_sel < fill_sel);
            cand_idx_next = ptr_reg;
            cand_rp_next  = rp_sel;
        end
        else if (cmd.drain)
        begin
            cand_vld_next = 1'b0;
        end

        // Compare stage; strict less keeps the lowest index on ties
        if ((cmd.scan_step || cmd.drain) && cand_vld_reg)
        begin
            if (!found_reg || ($signed(ram_rdata) < $signed(best_val_reg)))
            begin
                found_next    = 1'b1;
                best_idx_next = cand_idx_reg;
                best_rp_next  = cand_rp_reg;
                best_val_next = ram_rdata;
            end
        end

        if (out_vld_reg && rsp_ready)
        begin
            out_vld_next = 1'b0;
        end

        if (cmd.load_out)
        begin
            out_vld_next    = 1'b1;
            out_val_next    = '0;
            out_src_next    = '0;
            out_status_next = res_status_reg;
            if (act_reg == kwm_pkg::ACT_TAKE)
            begin
                if (found_reg)
                begin
                    out_status_next       = kwm_pkg::ST_TAKEN;
                    out_val_next          = best_val_reg;
                    out_src_next          = IW'(best_idx_reg);
                    rp_next[best_idx_reg] = CW'(best_rp_reg + 1'b1);
                end
                else
                begin
                    out_status_next = kwm_pkg::ST_EMPTY;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg <= req_action;
            idx_reg <= req_list_index;
            val_reg <= req_value;
        end
        ptr_reg        <= ptr_next;
        cand_idx_reg   <= cand_idx_next;
        cand_rp_reg    <= cand_rp_next;
        best_idx_reg   <= best_idx_next;
        best_rp_reg    <= best_rp_next;
        best_val_reg   <= best_val_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_val_reg    <= out_val_next;
        out_src_reg    <= out_src_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                fill_reg[i] <= '0;
                rp_reg[i]   <= '0;
            end
            cand_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            rp_reg       <= rp_next;
            cand_vld_reg <= cand_vld_next;
            found_reg    <= found_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    assign rsp_valid       = out_vld_reg;
    assign rsp_status      = out_status_reg;
    assign rsp_taken_value = out_val_reg;
    assign rsp_source_list = out_src_reg;

endmodule

>>> rtl/k_way_sorted_merge_unit.sv
// Top level of the k-way sorted merge unit.
//
//  channel | dir | payload                             | transfer when
//  --------+-----+-------------------------------------+---------------------
//  req     | in  | action, list_index, value           | req.valid & req.ready
//  rsp     | out | status, taken_value, source_list    | rsp.valid & rsp.ready
//
// A clear or append goes through accept, execute, and load into the output register.
// A take goes through accept, execute, one head read per list through the RAM read port,
// a last compare, and load. One item is in flight at a time.
// req.ready returns once the result is loaded, so the next request transfers while that
// result waits; a stalled response holds the next finished item until the register frees.
// Reset empties all lists; the element RAM is not cleared, only written entries are used.
`include "assert_macros.svh"

module k_way_sorted_merge_unit #(
    parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
    parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    kwm_req_if.sink   req,
    kwm_rsp_if.source rsp
);

    kwm_pkg::kwm_cmd_t  cmd;
    kwm_pkg::kwm_stat_t stat;

    // Sequencer: idle / execute / scan heads / drain compare / emit
    kwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Counters, element store, min search and output register
    kwm_dp #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_action      (req.action),
        .req_list_index  (req.list_index),
        .req_value       (req.value),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_status      (rsp.status),
        .rsp_taken_value (rsp.taken_value),
        .rsp_source_list (rsp.source_list)
    );

    // Only one controller command per cycle
    `KWM_ASSERT_ALWAYS(a_one_cmd, clk, rst_n, $onehot0(cmd))

    // A result is never written over one that has not been taken
    `KWM_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.load_out, !rsp.valid || rsp.ready)

    // One item at a time: no request transfer right after one
    `KWM_ASSERT_NEXT(a_single_item, clk, rst_n, req.valid && req.ready, !req.ready)

endmodule

>>> tb/sv/tb_k_way_sorted_merge_unit.sv
// Self-checking testbench for the k-way sorted merge unit.
module tb_k_way_sorted_merge_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF;
    localparam int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF;

    // Action code the block has no use for; it must answer "done" and change nothing.
    localparam logic [kwm_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Cycles without any transfer on either channel before the run is declared hung.
    // A take steps through every list; random stalls on both channels stretch it.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 2000;

    typedef struct packed {
        logic [kwm_pkg::STATUS_W-1:0]          status;
        logic signed [kwm_pkg::VALUE_W-1:0]    taken_value;
        logic [kwm_pkg::LIST_IDX_W-1:0]        source_list;
    } merge_result_t;

    // Keeps its own copy of the lists, works out the answer to every request
    // transfer and compares response transfers with the oldest answer pending.
    class merge_scoreboard;
        logic signed [kwm_pkg::VALUE_W-1:0] elements [NUM_LISTS][LIST_DEPTH];
        int unsigned                        fill     [NUM_LISTS];
        int unsigned                        head     [NUM_LISTS];
        merge_result_t                      expected_q [$];
        int unsigned                        mismatches;

        function new();
            mismatches = 0;
            empty_lists();
        endfunction

        function void empty_lists();
            foreach (fill[i])
            begin
                fill[i] = 0;
                head[i] = 0;
            end
        endfunction

        function void note_request(logic [kwm_pkg::ACTION_W-1:0] action,
                                   logic [kwm_pkg::LIST_IDX_W-1:0] list_idx,
                                   logic signed [kwm_pkg::VALUE_W-1:0] value);
            merge_result_t                      r;
            int                                 best;
            logic signed [kwm_pkg::VALUE_W-1:0] best_val;
            r        = '0;
            best     = -1;
            best_val = '0;
            case (action)
                kwm_pkg::ACT_CLEAR:
                begin
                    empty_lists();
                    r.status = kwm_pkg::ST_DONE;
                end
                kwm_pkg::ACT_APPEND:
                begin
                    if (list_idx >= NUM_LISTS || fill[list_idx] >= LIST_DEPTH)
                        r.status = kwm_pkg::ST_FULL;
                    else
                    begin
                        elements[list_idx][fill[list_idx]] = value;
                        fill[list_idx]++;
                        r.status = kwm_pkg::ST_DONE;
                    end
                end
                kwm_pkg::ACT_TAKE:
                begin
                    // strict less-than keeps the lowest index on equal heads
                    for (int l = 0; l < NUM_LISTS; l++)
                        if (head[l] < fill[l] &&
                            (best < 0 || elements[l][head[l]] < best_val))
                        begin
                            best     = l;
                            best_val = elements[l][head[l]];
                        end
                    if (best < 0)
                        r.status = kwm_pkg::ST_EMPTY;
                    else
                    begin
                        r.status      = kwm_pkg::ST_TAKEN;
                        r.taken_value = best_val;
                        r.source_list = best[kwm_pkg::LIST_IDX_W-1:0];
                        head[best]++;
                    end
                end
                default: r.status = kwm_pkg::ST_DONE;
            endcase
            expected_q = {expected_q, r};
        endfunction

        function void check_response(merge_result_t got);
            merge_result_t want;
            if (expected_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("[%0t] unexpected response: status=%0d value=%0d list=%0d",
                             $realtime, got.status, $signed(got.taken_value), got.source_list);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.taken_value !== want.taken_value ||
                got.source_list !== want.source_list)
            begin
                if (mismatches < 10)
                    $display("[%0t] mismatch: exp status=%0d value=%0d list=%0d, got status=%0d value=%0d list=%0d",
                             $realtime, want.status, $signed(want.taken_value), want.source_list,
                             got.status, $signed(got.taken_value), got.source_list);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    kwm_req_if req_ch ();
    kwm_rsp_if rsp_ch ();

    k_way_sorted_merge_unit #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    merge_scoreboard sb;
    bit              throttle_on;    // random idling on both channels when set
    int unsigned     requests_sent;  // request transfers, unused action code excluded
    int unsigned     stall_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Request side. valid is only lowered when an idle cycle is inserted,
    // so back-to-back transfers never see a low and a high in one step.
    // ready is sampled at the edge before the block's own updates land.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [kwm_pkg::ACTION_W-1:0]       action,
                                input logic [kwm_pkg::LIST_IDX_W-1:0]     list_idx,
                                input logic signed [kwm_pkg::VALUE_W-1:0] value);
        while (throttle_on && $urandom_range(0, 99) < 30)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= action;
        req_ch.list_index <= list_idx;
        req_ch.value      <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(action, list_idx, value);
        if (action != ACT_UNUSED)
            requests_sent++;
    endtask

    // Next element of an ascending list; saturates at the top of the range.
    function automatic logic signed [kwm_pkg::VALUE_W-1:0] next_ascending(
        logic signed [kwm_pkg::VALUE_W-1:0] prev,
        int unsigned                        spread);
        longint n;
        n = longint'(prev) + longint'($urandom_range(0, spread));
        if (n > 64'sd2147483647)
            n = 64'sd2147483647;
        return n[kwm_pkg::VALUE_W-1:0];
    endfunction

    // One round of the merge: fill a random subset of lists with ascending
    // runs, interleaved in random order, then drain them with takes and a few
    // extra takes past exhaustion. Noise sprinkled in: unused action code,
    // out-of-order appends, early takes. Now and then one list is pushed past
    // its depth so appends get dropped. Half the rounds end with a clear;
    // the others leave their lists behind for the next round to append to.
    task automatic merge_episode();
        int unsigned                        left   [NUM_LISTS];
        logic signed [kwm_pkg::VALUE_W-1:0] cursor [NUM_LISTS];
        int unsigned                        appended;
        int unsigned                        spread;
        int unsigned                        remaining;
        int unsigned                        roll;
        int                                 deep;
        int                                 l;
        appended = 0;
        // narrow spread with small starts gives lots of equal heads
        spread   = ($urandom_range(0, 2) == 0) ? 2 : (1 << $urandom_range(4, 24));
        deep     = ($urandom_range(0, 11) == 0) ? $urandom_range(0, NUM_LISTS - 1) : -1;
        for (l = 0; l < NUM_LISTS; l++)
        begin
            left[l] = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (l == deep)
                left[l] = LIST_DEPTH + $urandom_range(1, 3);
            if (spread == 2)
                cursor[l] = $signed($urandom_range(0, 8)) - 4;
            else
                cursor[l] = $urandom;
        end
        forever
        begin
            remaining = 0;
            foreach (left[i])
                remaining += left[i];
            if (remaining == 0)
                break;
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send_request(ACT_UNUSED, kwm_pkg::LIST_IDX_W'($urandom), $urandom);
            else if (roll < 8)
            begin
                send_request(kwm_pkg::ACT_APPEND, kwm_pkg::LIST_IDX_W'($urandom), $urandom);
                appended++;
            end
            else if (roll < 18)
                send_request(kwm_pkg::ACT_TAKE, kwm_pkg::LIST_IDX_W'($urandom), $urandom);
            else
            begin
                do
                    l = $urandom_range(0, NUM_LISTS - 1);
                while (left[l] == 0);
                send_request(kwm_pkg::ACT_APPEND, kwm_pkg::LIST_IDX_W'(l), cursor[l]);
                cursor[l] = next_ascending(cursor[l], spread);
                left[l]--;
                appended++;
            end
        end
        repeat (appended + $urandom_range(1, 3))
            send_request(kwm_pkg::ACT_TAKE, kwm_pkg::LIST_IDX_W'($urandom), $urandom);
        if ($urandom_range(0, 1) == 0)
            send_request(kwm_pkg::ACT_CLEAR, kwm_pkg::LIST_IDX_W'($urandom), $urandom);
    endtask

    // ------------------------------------------------------------------
    // Response side: check every transfer, then pick ready for the next
    // cycle. One assignment to ready per edge.
    // ------------------------------------------------------------------
    initial
    begin
        merge_result_t got;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status      = rsp_ch.status;
                got.taken_value = rsp_ch.taken_value;
                got.source_list = rsp_ch.source_list;
                sb.check_response(got);
            end
            rsp_ch.ready <= !throttle_on || $urandom_range(0, 99) >= 30;
        end
    end

    // Watchdog: any transfer on either side resets the count.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb            = new();
        throttle_on   = 1'b1;
        requests_sent = 0;
        stall_cycles  = 0;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.action     <= kwm_pkg::ACT_CLEAR;
        req_ch.list_index <= '0;
        req_ch.value      <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: take from empty store, unused code, extremes of value,
        // equal heads (lower list wins), an out-of-order list, exhaustion,
        // append after takes, and clear.
        send_request(kwm_pkg::ACT_TAKE,   3'd0, 32'sd0);
        send_request(ACT_UNUSED,          3'd7, -32'sd1);
        send_request(kwm_pkg::ACT_APPEND, 3'd0, 32'sh8000_0000);
        send_request(kwm_pkg::ACT_APPEND, 3'd7, 32'sh7fff_ffff);
        send_request(kwm_pkg::ACT_APPEND, 3'd3, -32'sd1);
        send_request(kwm_pkg::ACT_APPEND, 3'd3, 32'sd0);
        send_request(kwm_pkg::ACT_APPEND, 3'd5, 32'sd5);
        send_request(kwm_pkg::ACT_APPEND, 3'd2, 32'sd5);
        send_request(kwm_pkg::ACT_APPEND, 3'd1, 32'sd10);
        send_request(kwm_pkg::ACT_APPEND, 3'd1, 32'sd3);
        repeat (9)
            send_request(kwm_pkg::ACT_TAKE, 3'd0, 32'sd0);
        send_request(kwm_pkg::ACT_APPEND, 3'd4, 32'sd42);
        send_request(kwm_pkg::ACT_TAKE,   3'd6, 32'sd0);
        send_request(kwm_pkg::ACT_CLEAR,  3'd0, 32'sd0);
        send_request(kwm_pkg::ACT_TAKE,   3'd0, 32'sd0);

        // Random rounds; a stretch in the middle runs with no idling at all.
        requests_sent = 0;
        while (requests_sent < RANDOM_ITEMS)
        begin
            throttle_on = !(requests_sent >= 800 && requests_sent < 1100);
            merge_episode();
        end
        throttle_on = 1'b1;
        req_ch.valid <= 1'b0;

        // Drain, then give a late extra response time to show up.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (NUM_LISTS + 8) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> k_way_sorted_merge_unit.f
+incdir+rtl
rtl/kwm_pkg.sv
rtl/kwm_ifs.sv
rtl/kwm_ram.sv
rtl/kwm_ctrl.sv
rtl/kwm_dp.sv
rtl/k_way_sorted_merge_unit.sv
tb/sv/tb_k_way_sorted_merge_unit.sv
